// File: hdl/little_language_tokenizer_defines.svh
// Assertion macros for the tokenizer.
// Used by the top level; needs clk and rst_n in scope at the point of use.
`ifndef LITTLE_LANGUAGE_TOKENIZER_DEFINES_SVH
`define LITTLE_LANGUAGE_TOKENIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every rising edge out of reset
`define LLT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");
// next-cycle implication
`define LLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");
`else
`define LLT_ASSERT_IMPL(label, ante, cons)
`define LLT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/llt_pkg.sv
// Shared types and constants for the tokenizer.
// No dependencies; imported by llt_step and little_language_tokenizer.
package llt_pkg;

    localparam int MAX_TEXT_CHARS = 8;
    localparam int TEXT_W         = 64;
    localparam int COUNT_W        = 4;

    typedef logic [7:0]         char_t;
    typedef logic [4:0]         kind_t;
    typedef logic [TEXT_W-1:0]  text_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam kind_t K_LPAREN    = 5'd0;
    localparam kind_t K_RPAREN    = 5'd1;
    localparam kind_t K_NUMBER    = 5'd2;
    localparam kind_t K_IDENT     = 5'd3;
    localparam kind_t K_PLUS      = 5'd4;
    localparam kind_t K_MINUS     = 5'd5;
    localparam kind_t K_MULT      = 5'd6;
    localparam kind_t K_DIVIDE    = 5'd7;
    localparam kind_t K_IF        = 5'd8;
    localparam kind_t K_WHILE     = 5'd9;
    localparam kind_t K_SEMICOLON = 5'd10;
    localparam kind_t K_RCURLY    = 5'd11;
    localparam kind_t K_LCURLY    = 5'd12;
    localparam kind_t K_RETURN    = 5'd13;
    localparam kind_t K_FUNCTION  = 5'd14;
    localparam kind_t K_ASSIGN    = 5'd15;
    localparam kind_t K_EQUALS    = 5'd16;
    localparam kind_t K_LT        = 5'd17;
    localparam kind_t K_GT        = 5'd18;
    localparam kind_t K_LEQ       = 5'd19;
    localparam kind_t K_GEQ       = 5'd20;
    localparam kind_t K_EOF       = 5'd21;
    localparam kind_t K_PRINT     = 5'd22;
    localparam kind_t K_COMMA     = 5'd23;
    localparam kind_t K_ERROR     = 5'd24;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_AFTER_EQ = 3'd1,
        MODE_AFTER_LT = 3'd2,
        MODE_AFTER_GT = 3'd3,
        MODE_IN_ALPHA = 3'd4,
        MODE_IN_DIGIT = 3'd5
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t mode;
        text_t      text;
        count_t     count;
        logic       overflow;
    } scan_state_t;

    typedef struct packed {
        kind_t  kind;
        text_t  text;
        count_t length;
        logic   truncated;
        logic   last;
    } token_t;

    typedef struct packed {
        logic [1:0] num;
        token_t     tok0;
        token_t     tok1;
    } step_result_t;

endpackage

// File: hdl/llt_step.sv
// Combinational tokenizer step: one character against the scan state.
// Depends on llt_pkg. Gives the next scan state and up to two tokens.
module llt_step (
    input  llt_pkg::scan_state_t  st,
    input  llt_pkg::char_t        c,
    output llt_pkg::scan_state_t  st_next,
    output llt_pkg::step_result_t res
);
    import llt_pkg::*;

    localparam char_t CH_NUL    = 8'h00;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_PLUS   = 8'h2B;
    localparam char_t CH_COMMA  = 8'h2C;
    localparam char_t CH_MINUS  = 8'h2D;
    localparam char_t CH_SLASH  = 8'h2F;
    localparam char_t CH_SEMI   = 8'h3B;
    localparam char_t CH_LT     = 8'h3C;
    localparam char_t CH_EQ     = 8'h3D;
    localparam char_t CH_GT     = 8'h3E;
    localparam char_t CH_LCURLY = 8'h7B;
    localparam char_t CH_RCURLY = 8'h7D;

    // keyword spellings, first character in the low byte
    localparam text_t KW_F      = 64'h0000_0000_0000_0066;
    localparam text_t KW_IF     = 64'h0000_0000_0000_6669;
    localparam text_t KW_WHILE  = 64'h0000_0065_6C69_6877;
    localparam text_t KW_RETURN = 64'h0000_6E72_7574_6572;
    localparam text_t KW_PRINT  = 64'h0000_0074_6E69_7270;

    logic       is_space, is_alpha, is_digit, is_eq;
    logic       in_run, in_cmp, continue_run, pair, do_start;
    logic       pre_valid, start_emit;
    kind_t      start_kind;
    scan_mode_t start_mode;
    kind_t      run_kind;
    token_t     pre_tok, start_tok;
    text_t      appended;

    assign is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    assign is_digit = (c >= 8'h30 && c <= 8'h39);
    assign is_eq    = (c == CH_EQ);

    assign in_run = (st.mode == MODE_IN_ALPHA) || (st.mode == MODE_IN_DIGIT);
    assign in_cmp = (st.mode == MODE_AFTER_EQ) || (st.mode == MODE_AFTER_LT)
                 || (st.mode == MODE_AFTER_GT);
    assign continue_run = ((st.mode == MODE_IN_ALPHA) && is_alpha)
                       || ((st.mode == MODE_IN_DIGIT) && is_digit);
    assign pair      = in_cmp && is_eq;
    assign do_start  = !continue_run && !pair;
    assign pre_valid = in_cmp || (in_run && !continue_run);

    assign appended = st.text | (text_t'(c) << {st.count[2:0], 3'b000});

    // fresh start on a character
    always_comb
    begin
        start_emit = 1'b1;
        start_kind = K_ERROR;
        start_mode = MODE_IDLE;
        unique case (c)
            CH_NUL:    start_kind = K_EOF;
            CH_LPAREN: start_kind = K_LPAREN;
            CH_RPAREN: start_kind = K_RPAREN;
            CH_PLUS:   start_kind = K_PLUS;
            CH_MINUS:  start_kind = K_MINUS;
            CH_STAR:   start_kind = K_MULT;
            CH_SLASH:  start_kind = K_DIVIDE;
            CH_SEMI:   start_kind = K_SEMICOLON;
            CH_RCURLY: start_kind = K_RCURLY;
            CH_LCURLY: start_kind = K_LCURLY;
            CH_COMMA:  start_kind = K_COMMA;
            CH_EQ:
            begin
                start_emit = 1'b0;
                start_mode = MODE_AFTER_EQ;
            end
            CH_LT:
            begin
                start_emit = 1'b0;
                start_mode = MODE_AFTER_LT;
            end
            CH_GT:
            begin
                start_emit = 1'b0;
                start_mode = MODE_AFTER_GT;
            end
            default:
            begin
                priority if (is_space)
                    start_emit = 1'b0;
                else if (is_alpha)
                begin
                    start_emit = 1'b0;
                    start_mode = MODE_IN_ALPHA;
                end
                else if (is_digit)
                begin
                    start_emit = 1'b0;
                    start_mode = MODE_IN_DIGIT;
                end
                else
                    start_kind = K_ERROR;
            end
        endcase
    end

    // next scan state
    always_comb
    begin
        st_next = st;
        if (continue_run)
        begin
            if (st.count < COUNT_W'(MAX_TEXT_CHARS))
            begin
                st_next.text  = appended;
                st_next.count = st.count + count_t'(1);
            end
            else
                st_next.overflow = 1'b1;
        end
        else if (pair)
        begin
            st_next.mode     = MODE_IDLE;
            st_next.text     = '0;
            st_next.count    = '0;
            st_next.overflow = 1'b0;
        end
        else
        begin
            st_next.mode     = start_mode;
            st_next.overflow = 1'b0;
            if (is_alpha || is_digit)
            begin
                st_next.text  = text_t'(c);
                st_next.count = count_t'(1);
            end
            else
            begin
                st_next.text  = '0;
                st_next.count = '0;
            end
        end
    end

    // kind of a finished letter or digit run; truncated runs are never keywords
    always_comb
    begin
        priority if (st.mode == MODE_IN_DIGIT)
            run_kind = K_NUMBER;
        else if (st.overflow)
            run_kind = K_IDENT;
        else if (is_space && st.count == count_t'(1) && st.text == KW_F)
            run_kind = K_FUNCTION;
        else if (st.count == count_t'(2) && st.text == KW_IF)
            run_kind = K_IF;
        else if (st.count == count_t'(5) && st.text == KW_WHILE)
            run_kind = K_WHILE;
        else if (st.count == count_t'(6) && st.text == KW_RETURN)
            run_kind = K_RETURN;
        else if (st.count == count_t'(5) && st.text == KW_PRINT)
            run_kind = K_PRINT;
        else
            run_kind = K_IDENT;
    end

    // token outputs
    always_comb
    begin
        pre_tok = '0;
        unique case (st.mode)
            MODE_AFTER_EQ: pre_tok.kind = is_eq ? K_EQUALS : K_ASSIGN;
            MODE_AFTER_LT: pre_tok.kind = is_eq ? K_LEQ : K_LT;
            MODE_AFTER_GT: pre_tok.kind = is_eq ? K_GEQ : K_GT;
            MODE_IN_ALPHA, MODE_IN_DIGIT:
            begin
                pre_tok.kind = run_kind;
                if (run_kind == K_IDENT || run_kind == K_NUMBER)
                begin
                    pre_tok.text      = st.text;
                    pre_tok.length    = st.count;
                    pre_tok.truncated = st.overflow;
                end
            end
            default: pre_tok.kind = K_ERROR;
        endcase

        start_tok      = '0;
        start_tok.kind = start_kind;
        start_tok.last = 1'b1;

        res = '0;
        res.num  = 2'(pre_valid) + 2'(do_start && start_emit);
        res.tok1 = start_tok;
        if (pre_valid)
        begin
            res.tok0      = pre_tok;
            res.tok0.last = !(do_start && start_emit);
        end
        else
            res.tok0 = start_tok;
    end

endmodule

// File: hdl/little_language_tokenizer.sv
// Streaming tokenizer top level: scan state, two-slot token buffer, handshakes.
// Depends on llt_pkg, llt_step and little_language_tokenizer_defines.svh.
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-----------------------------------
//  character | in        | char_valid / char_stall  | char_code
//  token     | out       | token_valid / token_stall| token_kind, token_text,
//            |           |                          | text_length, text_truncated,
//            |           |                          | last_of_run
//
// One character a cycle while char_stall is low; the tokens it gives are registered and appear the next cycle.
// A character giving two tokens fills both slots of the buffer and holds char_stall
// high until the first of the two tokens has been taken downstream.
// char_stall falls in the same cycle a lone buffered token is taken downstream.
// rst_n clears the scan state and empties the buffer; no clearing pass is needed.
`include "little_language_tokenizer_defines.svh"

module little_language_tokenizer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  llt_pkg::char_t       char_code,
    output logic                 token_valid,
    input  logic                 token_stall,
    output llt_pkg::kind_t       token_kind,
    output llt_pkg::text_t       token_text,
    output llt_pkg::count_t      text_length,
    output logic                 text_truncated,
    output logic                 last_of_run
);
    import llt_pkg::*;

    // scan state: mode plus the partly built identifier or number
    scan_state_t  state_reg, state_next;
    step_result_t step_res;

    // token buffer: slot0 is the head, slot1 only holds the second of a pair
    token_t     slot0_reg, slot0_next;
    token_t     slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;

    logic accept, pop;

    llt_step u_step (
        .st      (state_reg),
        .c       (char_code),
        .st_next (state_next),
        .res     (step_res)
    );

    assign pop        = token_valid && !token_stall;
    // take a character once the buffer is, or is about to be, empty
    assign char_stall = !((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !token_stall));
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            slot0_next = step_res.tok0;
            slot1_next = step_res.tok1;
            cnt_next   = step_res.num;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode     <= MODE_IDLE;
            state_reg.text     <= '0;
            state_reg.count    <= '0;
            state_reg.overflow <= 1'b0;
            cnt_reg            <= 2'd0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    // token payload needs no reset; cnt_reg qualifies it
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign token_valid    = (cnt_reg != 2'd0);
    assign token_kind     = slot0_reg.kind;
    assign token_text     = slot0_reg.text;
    assign text_length    = slot0_reg.length;
    assign text_truncated = slot0_reg.truncated;
    assign last_of_run    = slot0_reg.last;

    // a lone buffered token always closes its character's run
    `LLT_ASSERT_IMPL(a_single_is_last, cnt_reg == 2'd1, slot0_reg.last)
    // a full buffer never takes a character
    `LLT_ASSERT_IMPL(a_full_stalls, cnt_reg == 2'd2, char_stall)
    // outside a run the text state is clear
    `LLT_ASSERT_IMPL(a_idle_text_clear,
        state_reg.mode != MODE_IN_ALPHA && state_reg.mode != MODE_IN_DIGIT,
        state_reg.text == '0 && state_reg.count == '0 && !state_reg.overflow)
    // the kept character count never passes the buffer size
    `LLT_ASSERT_IMPL(a_count_bound, 1'b1, state_reg.count <= COUNT_W'(MAX_TEXT_CHARS))
    // only identifiers and numbers carry text
    `LLT_ASSERT_IMPL(a_text_kinds,
        token_valid && token_kind != K_IDENT && token_kind != K_NUMBER,
        token_text == '0 && text_length == '0 && !text_truncated)

endmodule
